// ===== hw/rtl/rgb_levels_pixel_adjust_assert.svh =====
// assertion macros for the rgb levels pixel adjust block
`ifndef RGB_LEVELS_PIXEL_ADJUST_ASSERT_SVH
`define RGB_LEVELS_PIXEL_ADJUST_ASSERT_SVH
`ifndef SYNTHESIS
`define RLPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlpa assertion failed");
`define RLPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlpa assertion failed");
`else
`define RLPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/rlpa_pkg.sv =====
// package with widths, register indexes and types of the levels block
`timescale 1ns / 1ps
`default_nettype none
package rlpa_pkg;
    localparam int PIX_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int LEVELS_W  = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * PIX_W;

    localparam logic [PIX_W-1:0]    PIX_MAX  = 16'hFFFF;
    localparam logic [PIX_W-1:0]    BYTE_MAX = 16'h00FF;
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 64'h0000_0100_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 2'd3;

    typedef struct packed {
        logic load;
        logic wide;
        logic wide_s1;
    } t_chan_ctl;
endpackage
`default_nettype wire

// ===== hw/rtl/rlpa_in_if.sv =====
// input pixel channel: valid, ready and the input sample fields
`timescale 1ns / 1ps
`default_nettype none
interface rlpa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] blue_in;
    logic [15:0] green_in;
    logic [15:0] red_in;
    logic [15:0] alpha_in;

    modport source (output valid, output blue_in, output green_in, output red_in,
                    output alpha_in, input ready);
    modport sink (input valid, input blue_in, input green_in, input red_in,
                  input alpha_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rlpa_out_if.sv =====
// output pixel channel: valid, ready and the adjusted sample fields
`timescale 1ns / 1ps
`default_nettype none
interface rlpa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] blue_out;
    logic [15:0] green_out;
    logic [15:0] red_out;
    logic [15:0] alpha_out;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    output alpha_out, input ready);
    modport sink (input valid, input blue_out, input green_out, input red_out,
                  input alpha_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rlpa_channel.sv =====
// one colour channel: offsets and gain products, then sum and saturation
`timescale 1ns / 1ps
`default_nettype none
module rlpa_channel (
    input  wire logic                           i_clk,
    input  wire rlpa_pkg::t_chan_ctl            i_ctl,
    input  wire logic [rlpa_pkg::PIX_W-1:0]     i_sample,
    input  wire logic [rlpa_pkg::LEVELS_W-1:0]  i_levels,
    output logic      [rlpa_pkg::PIX_W-1:0]     o_result
);
    import rlpa_pkg::*;

    logic [PIX_W-1:0]  w_pre;
    logic [PIX_W-1:0]  w_post;
    logic [PIX_W-1:0]  w_gain_hi;
    logic [PIX_W-1:0]  w_gain_lo;
    logic [PIX_W-1:0]  w_top;
    logic [PIX_W-1:0]  w_c_in;
    logic [PIX_W:0]    w_c_sum;
    logic [PIX_W-1:0]  w_c_sat;
    logic [PIX_W-1:0]  w_c_off;
    logic [PROD_W-1:0] w_p_hi;
    logic [PROD_W-1:0] w_p_lo;
    logic [PIX_W:0]    w_wide_sum;

    logic [PIX_W-1:0]         r_hi_low;
    logic                     r_hi_nz;
    logic [PROD_W-BYTE_W-1:0] r_lo_top;

    assign w_pre     = i_levels[PIX_W-1:0];
    assign w_post    = i_levels[2*PIX_W-1:PIX_W];
    assign w_gain_lo = i_levels[3*PIX_W-1:2*PIX_W];
    assign w_gain_hi = i_levels[4*PIX_W-1:3*PIX_W];

    // front: pre-add, post-subtract, two half-gain products
    always_comb begin
        w_top   = i_ctl.wide ? PIX_MAX : BYTE_MAX;
        w_c_in  = i_ctl.wide ? i_sample : {{(PIX_W-BYTE_W){1'b0}}, i_sample[BYTE_W-1:0]};
        w_c_sum = {1'b0, w_c_in} + {1'b0, w_pre};
        w_c_sat = (w_c_sum > {1'b0, w_top}) ? w_top : w_c_sum[PIX_W-1:0];
        w_c_off = (w_c_sat > w_post) ? (w_c_sat - w_post) : '0;
        w_p_hi  = {{PIX_W{1'b0}}, w_c_off} * {{PIX_W{1'b0}}, w_gain_hi};
        w_p_lo  = {{PIX_W{1'b0}}, w_c_off} * {{PIX_W{1'b0}}, w_gain_lo};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hi_low <= w_p_hi[PIX_W-1:0];
            r_hi_nz  <= |w_p_hi;
            r_lo_top <= w_p_lo[PROD_W-1:BYTE_W];
        end
    end

    // back: combine halves and saturate to the channel maximum
    always_comb begin
        w_wide_sum = {1'b0, r_hi_low} + {1'b0, r_lo_top[PROD_W-BYTE_W-1:BYTE_W]};
        if (i_ctl.wide_s1) begin
            o_result = w_wide_sum[PIX_W] ? PIX_MAX : w_wide_sum[PIX_W-1:0];
        end else begin
            o_result = (r_hi_nz || (|r_lo_top[PROD_W-BYTE_W-1:BYTE_W])) ? BYTE_MAX
                     : {{(PIX_W-BYTE_W){1'b0}}, r_lo_top[BYTE_W-1:0]};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rgb_levels_pixel_adjust.sv =====
// top level of the rgb levels pixel adjust block
// One pixel per clock: a pixel is accepted in every cycle in which the two-stage
// pipeline can move. The first stage does the saturating pre-add and post-subtract
// and two 16x16 gain products per channel, the second sums and saturates into the
// output register. Ready drops only while both stages hold pixels and the output
// is stalled. Registers must be written by the user through the cfg port only
// while no pixel is in flight; the block does not enforce it. Alpha is copied.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_levels_pixel_adjust_assert.svh"
module rgb_levels_pixel_adjust (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rlpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rlpa_pkg::LEVELS_W-1:0]   i_cfg_data,
    rlpa_in_if.sink                              i_pix,
    rlpa_out_if.source                           o_pix
);
    import rlpa_pkg::*;

    logic                r_format;
    logic [LEVELS_W-1:0] r_red_levels;
    logic [LEVELS_W-1:0] r_green_levels;
    logic [LEVELS_W-1:0] r_blue_levels;

    logic             r_s1_valid;
    logic             n_s1_valid;
    logic             r_s1_wide;
    logic [PIX_W-1:0] r_s1_alpha;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [PIX_W-1:0] r_blue_out;
    logic [PIX_W-1:0] r_green_out;
    logic [PIX_W-1:0] r_red_out;
    logic [PIX_W-1:0] r_alpha_out;

    logic             w_s2_free;
    logic             w_in_ready;
    logic             w_in_beat;
    logic             w_s2_load;
    t_chan_ctl        w_ctl;
    logic [PIX_W-1:0] w_blue;
    logic [PIX_W-1:0] w_green;
    logic [PIX_W-1:0] w_red;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format       <= 1'b0;
            r_red_levels   <= LEVELS_RESET;
            r_green_levels <= LEVELS_RESET;
            r_blue_levels  <= LEVELS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FORMAT: r_format       <= i_cfg_data[0];
                REG_RED:    r_red_levels   <= i_cfg_data;
                REG_GREEN:  r_green_levels <= i_cfg_data;
                REG_BLUE:   r_blue_levels  <= i_cfg_data;
            endcase
        end
    end

    // pipeline control
    assign w_s2_free  = !r_out_valid || o_pix.ready;
    assign w_in_ready = !r_s1_valid || w_s2_free;
    assign w_in_beat  = i_pix.valid && w_in_ready;
    assign w_s2_load  = r_s1_valid && w_s2_free;

    always_comb begin
        n_s1_valid  = w_in_beat ? 1'b1 : (w_s2_free ? 1'b0 : r_s1_valid);
        n_out_valid = w_s2_free ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_s1_wide  <= r_format;
            r_s1_alpha <= i_pix.alpha_in;
        end
        if (w_s2_load) begin
            r_blue_out  <= w_blue;
            r_green_out <= w_green;
            r_red_out   <= w_red;
            r_alpha_out <= r_s1_alpha;
        end
    end

    assign w_ctl.load    = w_in_beat;
    assign w_ctl.wide    = r_format;
    assign w_ctl.wide_s1 = r_s1_wide;

    rlpa_channel u_blue (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (i_pix.blue_in),
        .i_levels (r_blue_levels),
        .o_result (w_blue)
    );

    rlpa_channel u_green (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (i_pix.green_in),
        .i_levels (r_green_levels),
        .o_result (w_green)
    );

    rlpa_channel u_red (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_sample (i_pix.red_in),
        .i_levels (r_red_levels),
        .o_result (w_red)
    );

    assign i_pix.ready     = w_in_ready;
    assign o_pix.valid     = r_out_valid;
    assign o_pix.blue_out  = r_blue_out;
    assign o_pix.green_out = r_green_out;
    assign o_pix.red_out   = r_red_out;
    assign o_pix.alpha_out = r_alpha_out;

    // a beat taken in lands in the first stage
    `RLPA_ASSERT_NXT(a_in_to_s1, i_clk, i_rst_n, w_in_beat, r_s1_valid)
    // a first-stage pixel is never dropped while the output is stalled
    `RLPA_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_s2_free, r_s1_valid)
    // a first-stage pixel moving on shows up at the output
    `RLPA_ASSERT_NXT(a_s1_to_out, i_clk, i_rst_n, w_s2_load, r_out_valid)
    // 8-bit results stay within a byte
    `RLPA_ASSERT_NXT(a_narrow_range, i_clk, i_rst_n, w_s2_load && !r_s1_wide,
        r_blue_out[15:8] == 8'h00 && r_green_out[15:8] == 8'h00 && r_red_out[15:8] == 8'h00)
endmodule
`default_nettype wire
